@@ rtl/core/rtpr_pkg.sv @@
package rtpr_pkg;

    localparam int unsigned COUNT_LIMIT = 65535;
    localparam int unsigned POS_W = 16;
    localparam int unsigned POS_CAP = (COUNT_LIMIT < 65535) ? COUNT_LIMIT : 65535;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(POS_CAP);

    localparam int unsigned DC_W = 7;
    localparam logic [DC_W-1:0] DC_MAX = 7'd127;

    localparam int unsigned CQ_DEPTH = 4;
    localparam int unsigned CQ_AW = $clog2(CQ_DEPTH);
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_AW = $clog2(OQ_DEPTH);

    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] RADIX_RESET = 6'd10;

    localparam logic [1:0] CFG_RADIX = 2'd0;
    localparam logic [1:0] CFG_TYPE_WIDTH = 2'd1;
    localparam logic [1:0] CFG_TYPE_SIGNED = 2'd2;

    localparam logic [1:0] TW_8 = 2'd0;
    localparam logic [1:0] TW_16 = 2'd1;
    localparam logic [1:0] TW_32 = 2'd2;
    localparam logic [1:0] TW_64 = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ZEROS  = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        FK_ZERO    = 2'd0,
        FK_INVALID = 2'd1,
        FK_CHECK   = 2'd2
    } t_fin_kind;

    typedef struct packed {
        logic [5:0] base;
        logic [1:0] width_code;
        logic       is_signed;
    } t_cfg;

    typedef struct packed {
        logic [5:0] digit;
        logic       is_digit;
        logic       is_zero;
        logic       sot;
        logic       eot;
        logic       minus;
    } t_cls;

    typedef struct packed {
        t_fin_kind         kind;
        logic [63:0]       acc;
        logic [DC_W-1:0]   dcount;
        logic              neg;
        logic [POS_W-1:0]  pos;
    } t_fin;

    typedef struct packed {
        t_status           status;
        logic [63:0]       value;
        logic [POS_W-1:0]  count;
    } t_res;

    localparam logic [6:0] DIGIT_LIMIT [0:34] = '{
        7'd64, 7'd41, 7'd32, 7'd28, 7'd25, 7'd23, 7'd22, 7'd21, 7'd20, 7'd19,
        7'd18, 7'd18, 7'd17, 7'd17, 7'd16, 7'd16, 7'd16, 7'd16, 7'd15, 7'd15,
        7'd15, 7'd15, 7'd14, 7'd14, 7'd14, 7'd14, 7'd14, 7'd14, 7'd14, 7'd13,
        7'd13, 7'd13, 7'd13, 7'd13, 7'd13
    };

    localparam logic [63:0] SAFE_MIN [0:34] = '{
        64'd9223372036854775808,  64'd12157665459056928801, 64'd4611686018427387904,
        64'd7450580596923828125,  64'd4738381338321616896,  64'd3909821048582988049,
        64'd9223372036854775808,  64'd12157665459056928801, 64'd10000000000000000000,
        64'd5559917313492231481,  64'd2218611106740436992,  64'd8650415919381337933,
        64'd2177953337809371136,  64'd6568408355712890625,  64'd1152921504606846976,
        64'd2862423051509815793,  64'd6746640616477458432,  64'd15181127029874798299,
        64'd1638400000000000000,  64'd3243919932521508681,  64'd6221821273427820544,
        64'd11592836324538749809, 64'd876488338465357824,   64'd1490116119384765625,
        64'd2481152873203736576,  64'd4052555153018976267,  64'd6502111422497947648,
        64'd10260628712958602189, 64'd15943230000000000000, 64'd787662783788549761,
        64'd1152921504606846976,  64'd1667889514952984961,  64'd2386420683693101056,
        64'd3379220508056640625,  64'd4738381338321616896
    };

endpackage

@@ rtl/core/rtpr_front.sv @@
module rtpr_front (
    input  logic [7:0]      i_ch,
    input  logic            i_start_of_text,
    input  logic            i_end_of_text,
    input  logic            i_minus_sign,
    input  logic [5:0]      i_base,
    output rtpr_pkg::t_cls  o_cls
);

    logic [5:0] digit;
    logic       known;

    always_comb begin
        digit = 6'd0;
        known = 1'b0;
        if (i_ch >= 8'd48 && i_ch <= 8'd57) begin
            digit = 6'(i_ch - 8'd48);
            known = 1'b1;
        end else if (i_ch >= 8'd97 && i_ch <= 8'd122) begin
            digit = 6'(i_ch - 8'd87);
            known = 1'b1;
        end else if (i_ch >= 8'd65 && i_ch <= 8'd90) begin
            digit = 6'(i_ch - 8'd55);
            known = 1'b1;
        end
    end

    always_comb begin
        o_cls.digit    = digit;
        o_cls.is_digit = known && (digit < i_base);
        o_cls.is_zero  = (i_ch == 8'd48);
        o_cls.sot      = i_start_of_text;
        o_cls.eot      = i_end_of_text;
        o_cls.minus    = i_minus_sign;
    end

endmodule

@@ rtl/core/rtpr_cq.sv @@
module rtpr_cq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  rtpr_pkg::t_cls  i_wdata,
    output logic            o_full,
    input  logic            i_rd,
    output logic            o_empty,
    output rtpr_pkg::t_cls  o_rdata
);

    rtpr_pkg::t_cls                 r_mem [0:rtpr_pkg::CQ_DEPTH-1];
    logic [rtpr_pkg::CQ_AW-1:0]     r_wr_ptr;
    logic [rtpr_pkg::CQ_AW-1:0]     r_rd_ptr;
    logic [rtpr_pkg::CQ_AW:0]       r_cnt;
    logic                           wr_ok;
    logic                           rd_ok;

    assign o_full  = (r_cnt == (rtpr_pkg::CQ_AW+1)'(rtpr_pkg::CQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_ok && !rd_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/rtpr_back.sv @@
module rtpr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rtpr_pkg::t_cfg  i_cfg,
    input  logic            i_cq_empty,
    input  rtpr_pkg::t_cls  i_cls,
    output logic            o_cq_rd,
    output logic            o_fin_valid,
    output rtpr_pkg::t_fin  o_fin,
    input  logic            i_fin_take
);

    rtpr_pkg::t_phase                  r_phase;
    rtpr_pkg::t_phase                  n_phase;
    rtpr_pkg::t_phase                  cur_phase;
    logic [63:0]                       r_acc;
    logic [63:0]                       n_acc;
    logic [rtpr_pkg::DC_W-1:0]         r_dc;
    logic [rtpr_pkg::DC_W-1:0]         n_dc;
    logic [rtpr_pkg::POS_W-1:0]        r_pos;
    logic [rtpr_pkg::POS_W-1:0]        n_pos;
    logic [rtpr_pkg::POS_W-1:0]        cur_pos;
    logic [rtpr_pkg::POS_W-1:0]        bump_pos;
    logic                              r_neg;
    logic                              n_neg;
    logic                              take;
    logic                              emit;
    rtpr_pkg::t_fin_kind               kind;
    logic [63:0]                       mac;
    logic                              r_fin_valid;
    rtpr_pkg::t_fin                    r_fin;

    assign take      = !i_cq_empty && (!r_fin_valid || i_fin_take);
    assign o_cq_rd   = take;
    assign cur_phase = i_cls.sot ? rtpr_pkg::PH_ZEROS : r_phase;
    assign cur_pos   = i_cls.sot ? '0 : r_pos;
    assign bump_pos  = (cur_pos < rtpr_pkg::POS_MAX) ? cur_pos + 1'b1 : cur_pos;
    assign mac       = 64'(r_acc * i_cfg.base) + 64'(i_cls.digit);

    always_comb begin
        n_phase = r_phase;
        if (take) begin
            if (i_cls.sot && !i_cls.is_digit) begin
                n_phase = rtpr_pkg::PH_IDLE;
            end else begin
                case (cur_phase)
                    rtpr_pkg::PH_ZEROS: begin
                        if (i_cls.is_zero) begin
                            n_phase = rtpr_pkg::PH_ZEROS;
                        end else if (i_cls.is_digit) begin
                            n_phase = rtpr_pkg::PH_DIGITS;
                        end else begin
                            n_phase = rtpr_pkg::PH_IDLE;
                        end
                    end
                    rtpr_pkg::PH_DIGITS: begin
                        n_phase = i_cls.is_digit ? rtpr_pkg::PH_DIGITS : rtpr_pkg::PH_IDLE;
                    end
                    default: begin
                        n_phase = rtpr_pkg::PH_IDLE;
                    end
                endcase
                if (i_cls.eot) begin
                    n_phase = rtpr_pkg::PH_IDLE;
                end
            end
        end
    end

    always_comb begin
        n_acc = r_acc;
        n_dc  = r_dc;
        n_pos = r_pos;
        n_neg = r_neg;
        emit  = 1'b0;
        kind  = rtpr_pkg::FK_ZERO;
        if (take) begin
            if (i_cls.sot) begin
                n_acc = '0;
                n_dc  = '0;
                n_pos = '0;
                n_neg = i_cls.minus & i_cfg.is_signed;
            end
            if (i_cls.sot && !i_cls.is_digit) begin
                emit = 1'b1;
                kind = rtpr_pkg::FK_INVALID;
            end else begin
                case (cur_phase)
                    rtpr_pkg::PH_ZEROS: begin
                        if (i_cls.is_zero) begin
                            n_pos = bump_pos;
                        end else if (i_cls.is_digit) begin
                            n_acc = 64'(i_cls.digit);
                            n_dc  = rtpr_pkg::DC_W'(1);
                            n_pos = bump_pos;
                        end else begin
                            emit = 1'b1;
                            kind = rtpr_pkg::FK_ZERO;
                        end
                    end
                    rtpr_pkg::PH_DIGITS: begin
                        if (i_cls.is_digit) begin
                            n_acc = mac;
                            n_dc  = (r_dc < rtpr_pkg::DC_MAX) ? r_dc + 1'b1 : r_dc;
                            n_pos = bump_pos;
                        end else begin
                            emit = 1'b1;
                            kind = rtpr_pkg::FK_CHECK;
                        end
                    end
                    default: begin
                        emit = 1'b0;
                    end
                endcase
                if (i_cls.eot && !emit && cur_phase != rtpr_pkg::PH_IDLE) begin
                    emit = 1'b1;
                    if (cur_phase == rtpr_pkg::PH_DIGITS
                            || (i_cls.is_digit && !i_cls.is_zero)) begin
                        kind = rtpr_pkg::FK_CHECK;
                    end else begin
                        kind = rtpr_pkg::FK_ZERO;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rtpr_pkg::PH_IDLE;
            r_acc       <= '0;
            r_dc        <= '0;
            r_pos       <= '0;
            r_neg       <= 1'b0;
            r_fin_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_dc    <= n_dc;
            r_pos   <= n_pos;
            r_neg   <= n_neg;
            if (take) begin
                r_fin_valid <= emit;
            end else if (i_fin_take) begin
                r_fin_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_fin.kind   <= kind;
            r_fin.acc    <= n_acc;
            r_fin.dcount <= n_dc;
            r_fin.neg    <= n_neg;
            r_fin.pos    <= n_pos;
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

endmodule

@@ rtl/core/rtpr_fin.sv @@
module rtpr_fin (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rtpr_pkg::t_cfg               i_cfg,
    input  logic                         i_fin_valid,
    input  rtpr_pkg::t_fin               i_fin,
    output logic                         o_fin_take,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [1:0]                   o_status,
    output logic [63:0]                  o_value_bits,
    output logic [rtpr_pkg::POS_W-1:0]   o_consumed_count
);

    logic [5:0]                     idx;
    logic [6:0]                     md;
    logic [63:0]                    safe;
    logic [63:0]                    tmax;
    logic [63:0]                    lim;
    logic                           over_digits;
    logic                           over_type;
    logic                           chk_type;
    rtpr_pkg::t_res                 res;

    rtpr_pkg::t_res                 r_mem [0:rtpr_pkg::OQ_DEPTH-1];
    logic [rtpr_pkg::OQ_AW-1:0]     r_wr_ptr;
    logic [rtpr_pkg::OQ_AW-1:0]     r_rd_ptr;
    logic [rtpr_pkg::OQ_AW:0]       r_cnt;
    logic                           full;
    logic                           wr_ok;
    logic                           rd_ok;

    assign idx  = i_cfg.base - rtpr_pkg::RADIX_MIN;
    assign md   = rtpr_pkg::DIGIT_LIMIT[idx];
    assign safe = rtpr_pkg::SAFE_MIN[idx];

    always_comb begin
        case (i_cfg.width_code)
            rtpr_pkg::TW_8:  tmax = i_cfg.is_signed ? 64'h7F : 64'hFF;
            rtpr_pkg::TW_16: tmax = i_cfg.is_signed ? 64'h7FFF : 64'hFFFF;
            rtpr_pkg::TW_32: tmax = i_cfg.is_signed ? 64'h7FFF_FFFF : 64'hFFFF_FFFF;
            default:         tmax = i_cfg.is_signed ? 64'h7FFF_FFFF_FFFF_FFFF : '1;
        endcase
    end

    assign lim         = tmax + 64'(i_fin.neg);
    assign chk_type    = !(i_cfg.width_code == rtpr_pkg::TW_64 && !i_cfg.is_signed);
    assign over_digits = (i_fin.dcount > md) || (i_fin.dcount == md && i_fin.acc < safe);
    assign over_type   = chk_type && (i_fin.acc > lim);

    always_comb begin
        res.count  = i_fin.pos;
        res.value  = '0;
        res.status = rtpr_pkg::ST_OK;
        case (i_fin.kind)
            rtpr_pkg::FK_INVALID: begin
                res.status = rtpr_pkg::ST_INVALID;
            end
            rtpr_pkg::FK_CHECK: begin
                if (over_digits || over_type) begin
                    res.status = rtpr_pkg::ST_RANGE;
                end else begin
                    res.value = i_fin.neg ? (64'd0 - i_fin.acc) : i_fin.acc;
                end
            end
            default: begin
                res.status = rtpr_pkg::ST_OK;
            end
        endcase
    end

    assign full       = (r_cnt == (rtpr_pkg::OQ_AW+1)'(rtpr_pkg::OQ_DEPTH));
    assign o_empty    = (r_cnt == '0);
    assign o_fin_take = !full;
    assign wr_ok      = i_fin_valid && !full;
    assign rd_ok      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_ok && !rd_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_status         = r_mem[r_rd_ptr].status;
    assign o_value_bits     = r_mem[r_rd_ptr].value;
    assign o_consumed_count = r_mem[r_rd_ptr].count;

endmodule

@@ rtl/core/radix_integer_text_parser_top.sv @@
// Streaming integer text parser, one character word per clock while full is low.
// Input channel: present a character with its start, end and sign marks and
// raise push; the word is taken at a rising edge where push is high and full
// is low. A word with the start mark opens a string; the sign is sampled
// from it. A string closes on its first non-digit or on the end mark, and
// that word produces one result word; words outside a string produce none.
// Result channel: while empty is low the oldest result (status, value,
// consumed count) is on the output ports; it is taken on an edge where pop
// is high. The result of the word that closes the string is registered in the
// back end, then written to the output queue. A new character is taken every
// cycle unless the back end stalls; its multiply-accumulate is combinational.
// If pop stays low, up to five results are held, four in the output queue and
// one in the back end; then the back end stalls and the input queue of four
// words fills until full rises.
// Configuration: write radix, type width code and type signedness over the
// cfg channel while the block is idle; it is always ready.
// Reset: synchronous, active low; both queues are emptied, any open string is
// dropped and the registers return to radix 10, 32-bit signed.
module radix_integer_text_parser_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   i_ch,
    input  logic                         i_start_of_text,
    input  logic                         i_end_of_text,
    input  logic                         i_minus_sign,
    output logic                         empty,
    input  logic                         pop,
    output logic [1:0]                   o_status,
    output logic [63:0]                  o_value_bits,
    output logic [rtpr_pkg::POS_W-1:0]   o_consumed_count,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [5:0]                   i_cfg_data
);

    logic [5:0]        r_radix;
    logic [1:0]        r_type_width_code;
    logic              r_type_signed;
    rtpr_pkg::t_cfg    cfg;
    rtpr_pkg::t_cls    cls_in;
    rtpr_pkg::t_cls    cls_out;
    logic              cq_empty;
    logic              cq_rd;
    logic              fin_valid;
    rtpr_pkg::t_fin    fin;
    logic              fin_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix           <= rtpr_pkg::RADIX_RESET;
            r_type_width_code <= rtpr_pkg::TW_32;
            r_type_signed     <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rtpr_pkg::CFG_RADIX:       r_radix <= i_cfg_data;
                rtpr_pkg::CFG_TYPE_WIDTH:  r_type_width_code <= i_cfg_data[1:0];
                rtpr_pkg::CFG_TYPE_SIGNED: r_type_signed <= i_cfg_data[0];
                default: begin
                    r_radix <= r_radix;
                end
            endcase
        end
    end

    always_comb begin
        if (r_radix < rtpr_pkg::RADIX_MIN) begin
            cfg.base = rtpr_pkg::RADIX_MIN;
        end else if (r_radix > rtpr_pkg::RADIX_MAX) begin
            cfg.base = rtpr_pkg::RADIX_MAX;
        end else begin
            cfg.base = r_radix;
        end
        cfg.width_code = r_type_width_code;
        cfg.is_signed  = r_type_signed;
    end

    rtpr_front u_front (
        .i_ch            (i_ch),
        .i_start_of_text (i_start_of_text),
        .i_end_of_text   (i_end_of_text),
        .i_minus_sign    (i_minus_sign),
        .i_base          (cfg.base),
        .o_cls           (cls_in)
    );

    rtpr_cq u_cq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (cls_in),
        .o_full  (full),
        .i_rd    (cq_rd),
        .o_empty (cq_empty),
        .o_rdata (cls_out)
    );

    rtpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cq_empty  (cq_empty),
        .i_cls       (cls_out),
        .o_cq_rd     (cq_rd),
        .o_fin_valid (fin_valid),
        .o_fin       (fin),
        .i_fin_take  (fin_take)
    );

    rtpr_fin u_fin (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_fin_valid      (fin_valid),
        .i_fin            (fin),
        .o_fin_take       (fin_take),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_status         (o_status),
        .o_value_bits     (o_value_bits),
        .o_consumed_count (o_consumed_count)
    );

endmodule
